// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the calendar converter RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/e2cal_pkg.sv =====
// Package for the epoch-seconds to calendar converter: constants, types, tables.
// Used by every module of the block; depends on nothing else.
package e2cal_pkg;

    localparam int SecW       = 32;
    localparam int DayQuotW   = 16;
    localparam int OutDataW   = 48;
    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    localparam logic [SecW-1:0]     MaxSecondsReset = 32'd4102444799;
    localparam logic [16:0]         SecPerDay       = 17'd86400;
    localparam logic [16:0]         SecPerHour      = 17'd3600;
    localparam logic [16:0]         SecPerMin       = 17'd60;
    localparam logic [DayQuotW-1:0] DaysTo2000      = 16'd10957;
    localparam logic [DayQuotW-1:0] DaysPer8Years   = 16'd2922;
    localparam logic [DayQuotW-1:0] WeekLen         = 16'd7;
    localparam logic [DayQuotW-1:0] Jan1st2000Wday  = 16'd6;
    localparam logic [7:0]          YearBase        = 8'd100;
    localparam logic [3:0]          LastMonth       = 4'd11;

    // Reciprocals for the constant divisions. 86400 is 675 * 128, 3600 is
    // 225 * 16 and 60 is 15 * 4, so the power-of-two part is shifted off
    // first and the odd part is a multiply by ceil(2^shift / divisor).
    localparam logic [25:0] DayRecip       = 26'd50903317;
    localparam int          DayRecipShift  = 35;
    localparam logic [13:0] HourRecip      = 14'd9321;
    localparam int          HourRecipShift = 21;
    localparam logic [10:0] MinRecip       = 11'd1093;
    localparam int          MinRecipShift  = 14;
    localparam logic [16:0] WdayRecip      = 17'd74899;
    localparam int          WdayRecipShift = 19;

    typedef logic [SecW-1:0] secs_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // One result; the last member sits in the lowest bits.
    typedef struct packed {
        logic [8:0] day_of_year;
        logic [2:0] day_of_week;
        logic [7:0] year_since_1900;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_t;

    function automatic logic leap_of(input logic [7:0] year);
        return (year[1:0] == 2'b00);
    endfunction

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] len;
        case (mon)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/e2cal_front.sv =====
// Front end of the calendar converter: input handshake, limit register, clamp.
// Depends on e2cal_pkg; pushes clamped second counts into e2cal_fifo.
module e2cal_front
    import e2cal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  secs_t   s_axis_tdata,   // [31:0] epoch_seconds
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  secs_t   cfg_data,       // [31:0] max_seconds
    input  q_stat_t q_stat,
    output logic    push,
    output secs_t   push_data
);

    secs_t max_seconds_reg;
    secs_t max_seconds_next;

    assign cfg_ready        = 1'b1;
    assign max_seconds_next = (cfg_valid && cfg_ready) ? cfg_data : max_seconds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_seconds_reg <= MaxSecondsReset;
        end
        else
        begin
            max_seconds_reg <= max_seconds_next;
        end
    end

    // Items above the limit are clamped before they enter the queue.
    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign push_data     = (s_axis_tdata > max_seconds_reg) ? max_seconds_reg : s_axis_tdata;

endmodule

// ===== rtl/e2cal_fifo.sv =====
// Short queue between the front end and the conversion engine.
// Depends on e2cal_pkg; the depth is a power of two so the pointers wrap freely.
module e2cal_fifo
    import e2cal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  secs_t   push_data,
    input  logic    pop,
    output secs_t   pop_data,
    output q_stat_t q_stat
);

    `include "assert_macros.svh"

    secs_t                entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg;
    logic [QueuePtrW-1:0] wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg;
    logic [QueuePtrW-1:0] rd_ptr_next;
    logic [QueuePtrW:0]   count_reg;
    logic [QueuePtrW:0]   count_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QueuePtrW+1)'(QueueDepth));
    assign q_stat.empty = (count_reg == '0);

    `ASSERT_ALWAYS(a_no_overflow, !(push && q_stat.full), "push into a full queue")
    `ASSERT_ALWAYS(a_no_underflow, !(pop && q_stat.empty), "pop from an empty queue")

endmodule

// ===== rtl/e2cal_back.sv =====
// Conversion engine: splits a clamped second count into calendar fields.
// Depends on e2cal_pkg; pops from e2cal_fifo and drives the result register.
module e2cal_back
    import e2cal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_stat_t             q_stat,
    input  secs_t               pop_data,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata
);

    `include "assert_macros.svh"

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SETUP, ST_CALC} state_t;
    typedef enum logic [1:0] {DP_BLOCK, DP_YEAR, DP_MONTH, DP_DONE} date_ph_t;
    typedef enum logic [2:0] {TP_HOUR, TP_HOUR_REM, TP_MIN, TP_MIN_REM, TP_DONE} time_ph_t;

    state_t               state_reg, state_next;
    secs_t                rem_reg, rem_next;
    logic [DayQuotW-1:0]  qday_reg, qday_next;
    logic [16:0]          tod_reg, tod_next;
    time_ph_t             tph_reg, tph_next;
    logic [4:0]           hour_reg, hour_next;
    logic [5:0]           minute_reg, minute_next;
    logic [DayQuotW-1:0]  wrem_reg, wrem_next;
    logic [12:0]          wq_reg, wq_next;
    date_ph_t             dph_reg, dph_next;
    logic [1:0]           bstep_reg, bstep_next;
    logic [DayQuotW-1:0]  day_reg, day_next;
    logic [7:0]           year_reg, year_next;
    logic [8:0]           yday_reg, yday_next;
    logic [3:0]           mon_reg, mon_next;
    logic                 out_valid_reg, out_valid_next;
    cal_t                 out_reg, out_next;

    logic [50:0]          day_prod;
    logic [16:0]          tod_sub;
    logic [25:0]          hour_prod;
    logic [19:0]          min_prod;
    logic [31:0]          wday_prod;
    logic [DayQuotW-1:0]  days_rel;
    logic [DayQuotW-1:0]  b_div;
    logic [8:0]           ylen;
    logic [4:0]           mlen;
    logic                 all_done;
    logic                 out_free;
    logic                 time_ok;
    logic                 date_ok;

    // Day quotient: seconds / 128 times the reciprocal of 675.
    assign day_prod = 51'(rem_reg[SecW-1:7]) * 51'(DayRecip);
    // The time of day is below 2^17, so the low bits of the product suffice.
    assign tod_sub  = 17'(qday_reg) * SecPerDay;
    assign days_rel = (qday_reg >= DaysTo2000) ? (qday_reg - DaysTo2000) : '0;

    // Hour, minute and weekday quotients by reciprocal multiplication.
    assign hour_prod = 26'(tod_reg[16:4]) * 26'(HourRecip);
    assign min_prod  = 20'(tod_reg[11:2]) * 20'(MinRecip);
    assign wday_prod = 32'(wrem_reg) * 32'(WdayRecip);

    // Date walk divisors.
    assign b_div = DaysPer8Years << bstep_reg;
    assign ylen  = year_len(leap_of(year_reg));
    assign mlen  = month_len(leap_of(year_reg), mon_reg);

    assign all_done = (tph_reg == TP_DONE) && (dph_reg == DP_DONE);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        qday_next      = qday_reg;
        tod_next       = tod_reg;
        tph_next       = tph_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        wrem_next      = wrem_reg;
        wq_next        = wq_reg;
        dph_next       = dph_reg;
        bstep_next     = bstep_reg;
        day_next       = day_reg;
        year_next      = year_reg;
        yday_next      = yday_reg;
        mon_next       = mon_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    rem_next   = pop_data;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                qday_next  = day_prod[DayRecipShift +: DayQuotW];
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                tod_next    = rem_reg[16:0] - tod_sub;
                tph_next    = TP_HOUR;
                wrem_next   = days_rel + Jan1st2000Wday;
                day_next    = days_rel;
                year_next   = YearBase;
                mon_next    = '0;
                bstep_next  = 2'd3;
                dph_next    = DP_BLOCK;
                state_next  = ST_CALC;
            end
            ST_CALC:
            begin
                case (tph_reg)
                    TP_HOUR:
                    begin
                        hour_next = hour_prod[HourRecipShift +: 5];
                        wq_next   = wday_prod[WdayRecipShift +: 13];
                        tph_next  = TP_HOUR_REM;
                    end
                    TP_HOUR_REM:
                    begin
                        tod_next  = tod_reg - 17'(hour_reg) * SecPerHour;
                        wrem_next = wrem_reg - 16'(wq_reg) * WeekLen;
                        tph_next  = TP_MIN;
                    end
                    TP_MIN:
                    begin
                        minute_next = min_prod[MinRecipShift +: 6];
                        tph_next    = TP_MIN_REM;
                    end
                    TP_MIN_REM:
                    begin
                        tod_next = tod_reg - 17'(minute_reg) * SecPerMin;
                        tph_next = TP_DONE;
                    end
                    default:
                    begin
                        tph_next = TP_DONE;
                    end
                endcase

                case (dph_reg)
                    DP_BLOCK:
                    begin
                        if (day_reg >= b_div)
                        begin
                            day_next  = day_reg - b_div;
                            year_next = year_reg + (8'd8 << bstep_reg);
                        end
                        bstep_next = bstep_reg - 2'd1;
                        if (bstep_reg == '0)
                        begin
                            dph_next = DP_YEAR;
                        end
                    end
                    DP_YEAR:
                    begin
                        if (day_reg >= {7'd0, ylen})
                        begin
                            day_next  = day_reg - {7'd0, ylen};
                            year_next = year_reg + 8'd1;
                        end
                        else
                        begin
                            yday_next = day_reg[8:0];
                            dph_next  = DP_MONTH;
                        end
                    end
                    DP_MONTH:
                    begin
                        if ((mon_reg < LastMonth) && (day_reg >= {11'd0, mlen}))
                        begin
                            day_next = day_reg - {11'd0, mlen};
                            mon_next = mon_reg + 4'd1;
                        end
                        else
                        begin
                            dph_next = DP_DONE;
                        end
                    end
                    default:
                    begin
                        dph_next = DP_DONE;
                    end
                endcase

                if (all_done && out_free)
                begin
                    out_next.second          = tod_reg[5:0];
                    out_next.minute          = minute_reg;
                    out_next.hour            = hour_reg;
                    out_next.day_of_month    = day_reg[4:0] + 5'd1;
                    out_next.month           = mon_reg;
                    out_next.year_since_1900 = year_reg;
                    out_next.day_of_week     = wrem_reg[2:0];
                    out_next.day_of_year     = yday_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            qday_reg      <= '0;
            tod_reg       <= '0;
            tph_reg       <= TP_DONE;
            hour_reg      <= '0;
            minute_reg    <= '0;
            wrem_reg      <= '0;
            wq_reg        <= '0;
            dph_reg       <= DP_DONE;
            bstep_reg     <= '0;
            day_reg       <= '0;
            year_reg      <= '0;
            yday_reg      <= '0;
            mon_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            qday_reg      <= qday_next;
            tod_reg       <= tod_next;
            tph_reg       <= tph_next;
            hour_reg      <= hour_next;
            minute_reg    <= minute_next;
            wrem_reg      <= wrem_next;
            wq_reg        <= wq_next;
            dph_reg       <= dph_next;
            bstep_reg     <= bstep_next;
            day_reg       <= day_next;
            year_reg      <= year_next;
            yday_reg      <= yday_next;
            mon_reg       <= mon_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OutDataW - $bits(cal_t))'(0), out_reg};

    assign time_ok = (out_reg.hour < 5'd24) && (out_reg.minute < 6'd60)
                     && (out_reg.second < 6'd60);
    assign date_ok = (out_reg.day_of_month != 5'd0) && (out_reg.month <= LastMonth)
                     && (out_reg.year_since_1900 >= YearBase)
                     && (out_reg.day_of_year < 9'd366) && (out_reg.day_of_week < 3'd7);

    `ASSERT_ALWAYS(a_time_range, !out_valid_reg || time_ok, "time of day out of range")
    `ASSERT_ALWAYS(a_date_range, !out_valid_reg || date_ok, "date out of range")
    `ASSERT_NEXT(a_pop_starts_div, pop, state_reg == ST_DIV, "pop did not start the day divider")

endmodule

// ===== rtl/epoch_seconds_to_calendar_top.sv =====
// Top level of the epoch-seconds to calendar converter.
// Depends on e2cal_pkg, e2cal_front, e2cal_fifo and e2cal_back.
//
//   Channel   Direction  Handshake                      Payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata[31:0] epoch_seconds
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata[45:0] calendar fields
//   cfg       in         cfg_valid / cfg_ready          cfg_data[31:0] max_seconds
//
// From queue head to result register, an item is popped, its day quotient is
// formed by reciprocal multiplication, its time of day is formed, and then the
// date walk runs over eight-year blocks, single years and months, which hides the
// four time-of-day and weekday steps. A waiting result holds the engine while the
// two-entry queue keeps taking input items. Reset is asynchronous and active low
// and sets the limit to 2099-12-31 23:59:59.
module epoch_seconds_to_calendar_top
    import e2cal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  secs_t               s_axis_tdata,  // [31:0] epoch_seconds
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [5:0] second, [11:6] minute, [16:12] hour, [21:17] day_of_month,
    // [25:22] month, [33:26] year_since_1900, [36:34] day_of_week,
    // [45:37] day_of_year, [47:46] zero
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  secs_t               cfg_data       // [31:0] max_seconds
);

    q_stat_t q_stat;
    logic    push;
    secs_t   push_data;
    logic    pop;
    secs_t   pop_data;

    // The front clamps each item to the limit register before queueing it.
    e2cal_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .q_stat        (q_stat),
        .push          (push),
        .push_data     (push_data)
    );

    // Clamped second counts wait here until the engine is free.
    e2cal_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // The engine converts one item at a time and holds the result until taken.
    e2cal_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_data      (pop_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the epoch-seconds to calendar converter.
// Needs e2cal_pkg and epoch_seconds_to_calendar_top; predicts each result in place.
`timescale 1ns / 1ps

module tb;

    import e2cal_pkg::*;

    // Calendar constants used by the local date predictor.
    localparam int unsigned DaySecs         = 86400;
    localparam int unsigned EightYearDays   = 2922;
    localparam int unsigned EpochTo2000Days = 10957;
    localparam int unsigned FirstYear       = 100;
    localparam int unsigned SaturdayIdx     = 6;
    localparam int unsigned LastMonthIdx    = 11;
    localparam int unsigned FebruaryIdx     = 1;

    // Register extremes and the value the block comes out of reset with.
    localparam logic [31:0] LimitAtReset = 32'd4102444799;
    localparam logic [31:0] LimitLowest  = 32'd946684800;
    localparam logic [31:0] LimitHighest = 32'hFFFF_FFFF;

    // First second of 2000 and of 2100 since the epoch.
    localparam logic [31:0] Start2000 = 32'd946684800;
    localparam logic [31:0] Start2100 = 32'd4102444800;

    // Cycles to let pass once nothing is expected; well above the worst item latency.
    localparam int SettleCycles = 60;
    // Length of the long hold-off on the result side.
    localparam int HoldCycles   = 300;

    // Month lengths of a common year; February gains a day in a leap year.
    localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    secs_t               s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_valid     = 1'b0;
    logic                cfg_ready;
    secs_t               cfg_data      = '0;

    // Predicted calendar results, oldest first, and the limit the predictor applies.
    cal_t        calendar_q [$];
    logic [31:0] limit_model = LimitAtReset;

    int errors          = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    // Long hold-off requests: the test bumps hold_asked, the receiver serves each one.
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;

    epoch_seconds_to_calendar_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Breaks a clamped second count down into the calendar fields. Dates before
    // 2000 collapse to 2000-01-01 but keep their time of day. Every fourth year
    // is taken as a leap year, 2100 included.
    function automatic cal_t to_calendar(input logic [31:0] secs, input logic [31:0] limit);
        int unsigned t;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        bit          leap;
        cal_t        c;
        t    = (secs > limit) ? limit : secs;
        days = t / DaySecs;
        tod  = t % DaySecs;
        days = (days >= EpochTo2000Days) ? days - EpochTo2000Days : 0;
        c.day_of_week = 3'((days + SaturdayIdx) % 7);
        yr = FirstYear;
        while (days >= EightYearDays)
        begin
            days -= EightYearDays;
            yr   += 8;
        end
        span = (yr % 4 == 0) ? 366 : 365;
        while (days >= span)
        begin
            days -= span;
            yr++;
            span = (yr % 4 == 0) ? 366 : 365;
        end
        c.day_of_year = 9'(days);
        leap = (yr % 4 == 0);
        mon  = 0;
        while (mon < LastMonthIdx)
        begin
            span = MonthDays[mon] + ((mon == FebruaryIdx && leap) ? 1 : 0);
            if (days < span)
                break;
            days -= span;
            mon++;
        end
        c.second          = 6'(tod % 60);
        c.minute          = 6'((tod / 60) % 60);
        c.hour            = 5'(tod / 3600);
        c.day_of_month    = 5'(days + 1);
        c.month           = 4'(mon);
        c.year_since_1900 = 8'(yr);
        return c;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor. Everything is sampled on the falling edge: the block's outputs
    // and our inputs are stable there, and a high valid/ready pair seen now is
    // the handshake of the next rising edge. Results are checked before the
    // input side is looked at so that the order within one edge never matters.
    always @(negedge clk)
    begin
        cal_t want;
        cal_t got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = cal_t'(m_axis_tdata[45:0]);
                if (calendar_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result item with nothing expected, actual %h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want = calendar_q.pop_front();
                    compare_field("second", want.second, got.second);
                    compare_field("minute", want.minute, got.minute);
                    compare_field("hour", want.hour, got.hour);
                    compare_field("day_of_month", want.day_of_month, got.day_of_month);
                    compare_field("month", want.month, got.month);
                    compare_field("year_since_1900", want.year_since_1900,
                                  got.year_since_1900);
                    compare_field("day_of_week", want.day_of_week, got.day_of_week);
                    compare_field("day_of_year", want.day_of_year, got.day_of_year);
                    compare_field("tdata padding", 0, m_axis_tdata[47:46]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                calendar_q.push_back(to_calendar(s_axis_tdata, limit_model));
        end
    end

    // Result side. Stalls at random, except during a requested long hold-off,
    // which it counts off here while the sender keeps offering items.
    always @(posedge clk)
    begin
        if (hold_asked != hold_served)
        begin
            hold_served = hold_asked;
            hold_left   = HoldCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // Offers one item after a random idle gap and returns at the rising edge
    // that takes it. Valid is left high, so back-to-back items need no toggle.
    task automatic send_seconds(input logic [31:0] secs);
        bit took;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Stops the input side and waits until every predicted result has come out,
    // then a little longer so the engine is surely idle.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (calendar_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    // The limit register is only written with the block idle.
    task automatic write_limit(input logic [31:0] value);
        bit took;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end
        while (!took);
        cfg_valid   <= 1'b0;
        limit_model  = value;
    endtask

    // Random second counts: anywhere in the 32-bit range, inside the usual
    // 2000..2099 span, right around a midnight, or before 2000.
    function automatic logic [31:0] pick_seconds();
        logic [31:0] secs;
        case ($urandom_range(3))
            0:       secs = $urandom;
            1:       secs = $urandom_range(LimitAtReset, Start2000);
            2:       secs = $urandom_range(49710, 10957) * DaySecs + 86398 + $urandom_range(3);
            default: secs = $urandom_range(Start2000 - 1, 0);
        endcase
        return secs;
    endfunction

    // Default limit: the pre-2000 clamp, leap days, year ends, the first
    // eight-year block boundary, the limit itself and values above it.
    task automatic test_default_limit;
        logic [31:0] cases [$] = '{
            32'd0, 32'd86399, Start2000 - 1, Start2000, Start2000 + 32'd1,
            32'd951782400, 32'd951868799, 32'd978264000, 32'd978307200,
            32'd983404799, 32'd1199145599, 32'd1199145600, 32'h5555_5555,
            32'hAAAA_AAAA, LimitAtReset, Start2100, LimitHighest
        };
        write_limit(LimitAtReset);
        foreach (cases[i])
            send_seconds(cases[i]);
    endtask

    // Full 32-bit range: 2100 counts as a leap year and the top input gives 2106.
    task automatic test_widest_limit;
        logic [31:0] cases [$] = '{
            Start2100 - 1, Start2100, 32'd4107542400, 32'd4107628799,
            32'd4133980800, 32'd4294944000, LimitHighest - 1, LimitHighest
        };
        write_limit(LimitHighest);
        foreach (cases[i])
            send_seconds(cases[i]);
        repeat (40) send_seconds(pick_seconds());
    endtask

    // Lowest limit: every date collapses to 2000-01-01, time of day still kept below it.
    task automatic test_narrowest_limit;
        logic [31:0] cases [$] = '{
            32'd0, 32'd43210, 32'd86399, Start2000 - 1, Start2000, Start2000 + 32'd1,
            LimitHighest
        };
        write_limit(LimitLowest);
        foreach (cases[i])
            send_seconds(cases[i]);
    endtask

    // Random items under each idling pattern, with a fresh random limit in the
    // middle of the run and the reset value around it.
    task automatic test_random_traffic;
        int idle_mix  [4] = '{0, 59, 0, 34};
        int stall_mix [4] = '{0, 0, 59, 34};
        write_limit(LimitAtReset);
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = idle_mix[phase];
            stall_pct       = stall_mix[phase];
            if (phase == 2)
                write_limit($urandom_range(LimitHighest, LimitLowest));
            if (phase == 3)
                write_limit(LimitAtReset);
            repeat (250) send_seconds(pick_seconds());
        end
    endtask

    // The result side holds off for a long stretch while items keep coming,
    // so the queue fills and the input side has to stall.
    task automatic test_backpressure;
        sender_idle_pct  = 0;
        stall_pct        = 0;
        hold_asked      <= hold_asked + 1;
        repeat (24) send_seconds(pick_seconds());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_default_limit();
        test_widest_limit();
        test_narrowest_limit();
        test_random_traffic();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("epoch_seconds_to_calendar_top verification clean");
        else
            $display("epoch_seconds_to_calendar_top verification failed");
        $finish;
    end

    // A correct run needs well under a tenth of this.
    initial
    begin
        #5_000_000;
        $display("epoch_seconds_to_calendar_top verification failed");
        $finish;
    end

endmodule
